[hw/rtl/lru_cache_with_byte_budget_top_defines.svh]
// Assertion macros for the LRU cache block
`ifndef LRU_CACHE_WITH_BYTE_BUDGET_TOP_DEFINES_SVH
`define LRU_CACHE_WITH_BYTE_BUDGET_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define LCB_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequence in the next cycle
`define LCB_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared types, constants and result codes of the LRU cache block.
// ----------------------------------------------------------------------------
package lcb_pkg;
    localparam int unsigned LCB_ENTRIES  = 16;
    localparam int unsigned LCB_KEY_BITS = 64;

    localparam logic [2:0] KIND_HIT     = 3'd0;
    localparam logic [2:0] KIND_MISS    = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_UPDATE  = 3'd3;
    localparam logic [2:0] KIND_REJECT  = 3'd4;
    localparam logic [2:0] KIND_EVICT   = 3'd5;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [31:0] RST_MAX_BYTES   = 32'd16777216;
    localparam logic [4:0]  RST_ENTRY_LIMIT = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture input item
        logic touch;   // make matched entry most recent
        logic update;  // overwrite matched entry
        logic evict;   // drop LRU entry
        logic insert;  // insert into free slot
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_put;
        logic hit;
        logic need_evict;
        logic too_large;
        logic no_free;
    } t_sts;
endpackage

[hw/rtl/lru_cache_with_byte_budget_top.sv]
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget_top
// Fully associative LRU table with entry limit and byte budget.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries requests (get or put); each beat yields one or more
//   result beats on the master stream, the final one marked by tlast.
//   A get or a put to a present key passes through capture, one compare/update
//   step and one settle state before the next accept. A put to a new key
//   repeats the compare step once per evicted entry; the eviction loop over
//   the shared LRU search runs before the insert, and a new request is only
//   taken once the sequencer is back in idle. The compare step registers a result.
//   APB port sets the byte budget (0x0) and the entry limit (0x4); write only
//   when idle.
//   Reset empties the table, zeroes the byte total and restores defaults.
//   A stalled master side holds the result register and the sequencer waits
//   for it; no result is lost or repeated.
// ----------------------------------------------------------------------------
`include "lru_cache_with_byte_budget_top_defines.svh"
module lru_cache_with_byte_budget_top import lcb_pkg::*; #(
    parameter int unsigned ENTRIES  = LCB_ENTRIES,
    parameter int unsigned KEY_BITS = LCB_KEY_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // key[63:0], handle[95:64], item_size[127:96]
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // out_handle[31:0], result size[63:32]
    output logic [2:0]   m_axis_tuser,  // kind[2:0]
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam logic [2:0] ADDR_MAX_BYTES   = 3'h0;
    localparam logic [2:0] ADDR_ENTRY_LIMIT = 3'h4;

    logic [31:0] r_max_bytes;
    logic [4:0]  r_entry_limit;
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] hit_h, hit_s, lru_h, lru_s;
    logic [2:0]  kind;
    logic [31:0] oh, os;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= RST_MAX_BYTES; r_entry_limit <= RST_ENTRY_LIMIT;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ADDR_MAX_BYTES:   r_max_bytes <= pwdata;
                ADDR_ENTRY_LIMIT: r_entry_limit <= pwdata[4:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            ADDR_MAX_BYTES:   prdata = r_max_bytes;
            ADDR_ENTRY_LIMIT: prdata = {27'd0, r_entry_limit};
            default:          prdata = '0;
        endcase
    end

    lcb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_kind(kind), .o_handle(oh), .o_size(os), .o_last(m_axis_tlast),
        .o_cmd(cmd), .i_sts(sts),
        .i_hit_handle(hit_h), .i_hit_size(hit_s),
        .i_lru_handle(lru_h), .i_lru_size(lru_s)
    );

    lcb_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_action(s_axis_tuser), .i_key(s_axis_tdata[63:0]),
        .i_handle(s_axis_tdata[95:64]), .i_size(s_axis_tdata[127:96]),
        .i_max_bytes(r_max_bytes), .i_entry_limit(r_entry_limit),
        .o_hit_handle(hit_h), .o_hit_size(hit_s),
        .o_lru_handle(lru_h), .o_lru_size(lru_s)
    );

    assign m_axis_tdata = {os, oh};
    assign m_axis_tuser = kind;

    // at most one table command per cycle
    `LCB_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(cmd), "multiple table commands")
    // an accepted request is never taken while a table command runs
    `LCB_ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, cmd.load,
        !(cmd.evict || cmd.insert || cmd.update || cmd.touch), "load during command")
    // eviction result is never the final beat
    `LCB_ASSERT_NEXT(a_evict_notlast, i_clk, i_rst_n, cmd.evict,
        m_axis_tvalid && !m_axis_tlast, "evict beat marked last")
endmodule

[hw/rtl/lcb_datapath.sv]
// ----------------------------------------------------------------------------
// lcb_datapath
// Entry table, recency ranks, byte total and lookup/eviction logic.
// ----------------------------------------------------------------------------
module lcb_datapath import lcb_pkg::*; #(
    parameter int unsigned ENTRIES  = LCB_ENTRIES,
    parameter int unsigned KEY_BITS = LCB_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_handle,
    input  logic [31:0] i_size,
    input  logic [31:0] i_max_bytes,
    input  logic [4:0]  i_entry_limit,
    output logic [31:0] o_hit_handle,
    output logic [31:0] o_hit_size,
    output logic [31:0] o_lru_handle,
    output logic [31:0] o_lru_size
);
    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0] r_key_tab [ENTRIES];
    logic [31:0]         r_hdl_tab [ENTRIES];
    logic [31:0]         r_sz_tab  [ENTRIES];
    logic [IW-1:0]       r_rank    [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [35:0]         r_total;
    logic [CW-1:0]       r_count;

    logic                r_act;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_hdl;
    logic [31:0]         r_sz;

    logic [ENTRIES-1:0] match;
    logic [IW-1:0]      hit_idx, lru_idx, free_idx;
    logic               hit, has_free;
    logic [5:0]         limit;

    // associative match and slot searches
    always_comb begin
        hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0; lru_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key_tab[i] == r_key);
            if (match[i] && !hit) begin
                hit = 1'b1; hit_idx = IW'(i);
            end
            if (!r_valid[i] && !has_free) begin
                has_free = 1'b1; free_idx = IW'(i);
            end
            if (r_valid[i] && r_rank[i] == IW'(r_count - CW'(1))) lru_idx = IW'(i);
        end
    end

    always_comb begin
        limit = (6'(i_entry_limit) > 6'(ENTRIES)) ? 6'(ENTRIES) : 6'(i_entry_limit);
        o_sts.is_put     = r_act;
        o_sts.hit        = hit;
        o_sts.need_evict = (r_count != '0) &&
            ((6'(r_count) >= limit) || (r_total + 36'(r_sz) > 36'(i_max_bytes)));
        o_sts.too_large  = r_sz > i_max_bytes;
        o_sts.no_free    = !has_free;
    end

    assign o_hit_handle = r_hdl_tab[hit_idx];
    assign o_hit_size   = r_sz_tab[hit_idx];
    assign o_lru_handle = r_hdl_tab[lru_idx];
    assign o_lru_size   = r_sz_tab[lru_idx];

    // capture item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_key <= i_key[KEY_BITS-1:0];
            r_hdl <= i_handle;
            r_sz  <= i_size;
        end
    end

    // table payload and ranks
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if ((i_cmd.touch || i_cmd.update) && r_valid[i] && IW'(i) != hit_idx
                && r_rank[i] < r_rank[hit_idx])
                r_rank[i] <= r_rank[i] + IW'(1);
            if (i_cmd.insert && r_valid[i]) r_rank[i] <= r_rank[i] + IW'(1);
        end
        if (i_cmd.touch || i_cmd.update) r_rank[hit_idx] <= '0;
        if (i_cmd.update) begin
            r_hdl_tab[hit_idx] <= r_hdl;
            r_sz_tab[hit_idx]  <= r_sz;
        end
        if (i_cmd.insert) begin
            r_key_tab[free_idx] <= r_key;
            r_hdl_tab[free_idx] <= r_hdl;
            r_sz_tab[free_idx]  <= r_sz;
            r_rank[free_idx]    <= '0;
        end
    end

    // valid bits, byte total, count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_total <= '0; r_count <= '0;
        end else begin
            if (i_cmd.update)
                r_total <= r_total - 36'(r_sz_tab[hit_idx]) + 36'(r_sz);
            if (i_cmd.evict) begin
                r_valid[lru_idx] <= 1'b0;
                r_total <= r_total - 36'(r_sz_tab[lru_idx]);
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.insert) begin
                r_valid[free_idx] <= 1'b1;
                r_total <= r_total + 36'(r_sz);
                r_count <= r_count + CW'(1);
            end
        end
    end
endmodule

[hw/rtl/lcb_ctrl.sv]
// ----------------------------------------------------------------------------
// lcb_ctrl
// Sequencer for lookup, update, eviction loop and insertion; owns output reg.
// ----------------------------------------------------------------------------
module lcb_ctrl import lcb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_handle,
    output logic [31:0] o_size,
    output logic        o_last,
    output t_cmd        o_cmd,
    input  t_sts        i_sts,
    input  logic [31:0] i_hit_handle,
    input  logic [31:0] i_hit_size,
    input  logic [31:0] i_lru_handle,
    input  logic [31:0] i_lru_size
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]  r_state, n_state;
    logic        r_ov;
    logic [2:0]  r_kind;
    logic [31:0] r_hdl, r_sz;
    logic        r_last;
    logic        emit;
    logic [2:0]  e_kind;
    logic [31:0] e_hdl, e_sz;
    logic        e_last;

    wire out_free = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // decide the next step of the item
    always_comb begin
        o_cmd = '0; n_state = r_state; emit = 1'b0;
        e_kind = KIND_MISS; e_hdl = '0; e_sz = '0; e_last = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!i_sts.is_put) begin
                        n_state = ST_WAIT;
                        if (i_sts.hit) begin
                            o_cmd.touch = 1'b1;
                            e_kind = KIND_HIT; e_hdl = i_hit_handle; e_sz = i_hit_size;
                        end
                    end else if (i_sts.hit) begin
                        n_state = ST_WAIT; o_cmd.update = 1'b1;
                        e_kind = KIND_UPDATE; e_hdl = i_hit_handle;
                    end else if (i_sts.need_evict) begin
                        o_cmd.evict = 1'b1; e_last = 1'b0;
                        e_kind = KIND_EVICT; e_hdl = i_lru_handle; e_sz = i_lru_size;
                    end else if (i_sts.too_large || i_sts.no_free) begin
                        n_state = ST_WAIT; e_kind = KIND_REJECT;
                    end else begin
                        n_state = ST_WAIT; o_cmd.insert = 1'b1; e_kind = KIND_INSERT;
                    end
                end
            end
            ST_WAIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= e_kind; r_hdl <= e_hdl; r_sz <= e_sz; r_last <= e_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind = r_kind;
    assign o_handle = r_hdl;
    assign o_size = r_sz;
    assign o_last = r_last;
endmodule
